[src/sha256md_pkg.sv]
// shared types, constants and round functions for the sha-256 digest block
// no dependencies; imported by every module of the block
`default_nettype none

package sha256md_pkg;

    // one input beat: message byte plus flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_of_message;
    } t_in_beat;

    // one output beat: digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    // 512-bit block, byte 0 and word 0 in the most significant bits
    typedef logic [0:63][7:0]  t_blk_bytes;
    typedef logic [0:15][31:0] t_blk_words;
    typedef logic [0:7][31:0]  t_hash_words;

    // block handed from front end to compression engine
    typedef struct packed {
        t_blk_words words;
        logic       final_blk;
    } t_blk_entry;

    typedef enum logic [1:0] {
        F_ACCEPT,
        F_PAD,
        F_LEN
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROUND,
        B_ADD,
        B_OUT
    } t_back_state;

    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    localparam t_hash_words H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // round function sigma terms, rotations written as concatenations
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

[src/sha256_message_digest.sv]
// SHA-256 digest of a byte stream. Bytes enter at up to one per cycle into
// the front end, which packs 64-byte blocks and appends the padding and the
// 64-bit bit length when a beat flagged last_of_message arrives (one or two
// extra blocks). Blocks pass through a queue of QUEUE_DEPTH entries to the
// compression engine, which runs one round per cycle: each block takes a
// load, 64 rounds and a chaining add, and the round loop sets the sustained
// rate. The input stalls while the queue is full and while the padding
// blocks are pushed. After the final block the eight digest words leave h0
// first, one per beat, the eighth flagged last_word, and the chaining value
// returns to the standard initial hash. No clearing pass after reset.
// top level; depends on sha256md_pkg, sha256md_front, sha256md_queue, sha256md_core
`default_nettype none

module sha256_message_digest #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  sha256md_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output sha256md_pkg::t_out_beat o_out_beat
);
    import sha256md_pkg::*;

    logic       push;
    t_blk_entry push_data;
    logic       pop;
    logic       full;
    logic       empty;
    t_blk_entry head;

    // byte packing and padding
    sha256md_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // block queue
    sha256md_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_head      (head)
    );

    // compression and digest output
    sha256md_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

[src/sha256md_front.sv]
// front end: packs message bytes into blocks, counts bits, builds padding
// depends on sha256md_pkg; feeds sha256md_queue
`default_nettype none

module sha256md_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  sha256md_pkg::t_in_beat   i_in_beat,
    input  wire                      i_full,
    output logic                     o_push,
    output sha256md_pkg::t_blk_entry o_push_data
);
    import sha256md_pkg::*;

    t_front_state r_fstate, n_fstate;
    t_blk_bytes   r_bytes;
    logic [5:0]   r_fill;
    logic [63:0]  r_len;

    logic         accept;
    t_blk_bytes   byte_blk;
    t_blk_bytes   pad_blk;
    t_blk_words   pad_len_blk;
    t_blk_words   len_blk;

    assign accept = i_in_valid && !o_in_stall;

    // current block with the incoming byte written in
    always_comb begin
        byte_blk = r_bytes;
        if (i_in_beat.has_byte) begin
            byte_blk[r_fill] = i_in_beat.data_byte;
        end
    end

    // padded block: kept bytes, marker, zeros; length goes in the last two words
    always_comb begin
        for (int p = 0; p < 64; p++) begin
            if (6'(p) < r_fill) begin
                pad_blk[p] = r_bytes[p];
            end else if (6'(p) == r_fill) begin
                pad_blk[p] = PAD_MARK;
            end else begin
                pad_blk[p] = '0;
            end
        end
        pad_len_blk     = t_blk_words'(pad_blk);
        pad_len_blk[14] = r_len[63:32];
        pad_len_blk[15] = r_len[31:0];
        len_blk         = '0;
        len_blk[14]     = r_len[63:32];
        len_blk[15]     = r_len[31:0];
    end

    // next state
    always_comb begin
        n_fstate = r_fstate;
        case (r_fstate)
            F_ACCEPT: begin
                if (accept && i_in_beat.last_of_message) begin
                    n_fstate = F_PAD;
                end
            end
            F_PAD: begin
                if (!i_full) begin
                    n_fstate = (r_fill >= LEN_FIELD_POS) ? F_LEN : F_ACCEPT;
                end
            end
            F_LEN: begin
                if (!i_full) begin
                    n_fstate = F_ACCEPT;
                end
            end
            default: n_fstate = F_ACCEPT;
        endcase
    end

    // outputs: stall, block push
    always_comb begin
        o_in_stall  = (r_fstate != F_ACCEPT) || i_full;
        o_push      = 1'b0;
        o_push_data = '{words: t_blk_words'(byte_blk), final_blk: 1'b0};
        case (r_fstate)
            F_ACCEPT: begin
                o_push = accept && i_in_beat.has_byte && (r_fill == LAST_BYTE_POS);
            end
            F_PAD: begin
                o_push = !i_full;
                if (r_fill >= LEN_FIELD_POS) begin
                    o_push_data = '{words: t_blk_words'(pad_blk), final_blk: 1'b0};
                end else begin
                    o_push_data = '{words: pad_len_blk, final_blk: 1'b1};
                end
            end
            F_LEN: begin
                o_push      = !i_full;
                o_push_data = '{words: len_blk, final_blk: 1'b1};
            end
            default: o_push = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_ACCEPT;
            r_fill   <= '0;
            r_len    <= '0;
        end else begin
            r_fstate <= n_fstate;
            if (o_push && o_push_data.final_blk) begin
                r_fill <= '0;
                r_len  <= '0;
            end else if (accept && i_in_beat.has_byte) begin
                r_fill <= r_fill + 6'd1;
                r_len  <= r_len + 64'd8;
            end
        end
    end

    // block bytes
    always_ff @(posedge i_clk) begin
        if (accept && i_in_beat.has_byte) begin
            r_bytes <= byte_blk;
        end
    end

endmodule

`default_nettype wire

[src/sha256md_queue.sv]
// short block queue between front end and compression engine
// depends on sha256md_pkg
`default_nettype none

module sha256md_queue #(
    parameter int DEPTH = 2
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  sha256md_pkg::t_blk_entry i_push_data,
    input  wire                      i_pop,
    output logic                     o_full,
    output logic                     o_empty,
    output sha256md_pkg::t_blk_entry o_head
);
    import sha256md_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_blk_entry    r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

[src/sha256md_core.sv]
// compression engine: one round per cycle, chaining value, digest output
// depends on sha256md_pkg; takes blocks from sha256md_queue
`default_nettype none

module sha256md_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_empty,
    input  sha256md_pkg::t_blk_entry i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output sha256md_pkg::t_out_beat  o_out_beat
);
    import sha256md_pkg::*;

    t_back_state r_bstate, n_bstate;
    t_hash_words r_chain;
    t_hash_words r_wv;
    t_blk_words  r_sched;
    logic [5:0]  r_round;
    logic        r_final;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic        load_out;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] new_w;
    t_hash_words n_wv;
    t_blk_words  n_sched;

    // one round and the next schedule word
    always_comb begin
        ch      = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
        maj     = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
        t1      = r_wv[7] + big_sigma1(r_wv[4]) + ch + ROUND_K[r_round] + r_sched[0];
        t2      = big_sigma0(r_wv[0]) + maj;
        n_wv    = {t1 + t2, r_wv[0], r_wv[1], r_wv[2],
                   r_wv[3] + t1, r_wv[4], r_wv[5], r_wv[6]};
        new_w   = r_sched[0] + small_sigma0(r_sched[1]) + r_sched[9]
                + small_sigma1(r_sched[14]);
        n_sched = {r_sched[1:15], new_w};
    end

    // next state
    always_comb begin
        n_bstate = r_bstate;
        case (r_bstate)
            B_IDLE: begin
                if (!i_empty) begin
                    n_bstate = B_ROUND;
                end
            end
            B_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_bstate = B_ADD;
                end
            end
            B_ADD: begin
                n_bstate = r_final ? B_OUT : B_IDLE;
            end
            B_OUT: begin
                if (load_out && (r_idx == LAST_WORD_IDX)) begin
                    n_bstate = B_IDLE;
                end
            end
            default: n_bstate = B_IDLE;
        endcase
    end

    // outputs: queue pop, output register load
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_bstate)
            B_IDLE:  o_pop    = !i_empty;
            B_OUT:   load_out = !r_out_valid || !i_out_stall;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // control and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= B_IDLE;
            r_chain     <= H_INIT;
            r_round     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            if (o_pop) begin
                r_round <= '0;
            end else if (r_bstate == B_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (r_bstate == B_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_wv[i];
                end
                r_idx <= '0;
            end else if (load_out) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == LAST_WORD_IDX) begin
                    r_chain <= H_INIT;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working variables, schedule window, output beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sched <= i_head.words;
            r_wv    <= r_chain;
            r_final <= i_head.final_blk;
        end else if (r_bstate == B_ROUND) begin
            r_sched <= n_sched;
            r_wv    <= n_wv;
        end
        if (load_out) begin
            r_out <= '{digest_word: r_chain[r_idx], word_index: r_idx,
                       last_word: (r_idx == LAST_WORD_IDX)};
        end
    end

    // the add step follows exactly the last round
    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == B_ADD) |-> ($past(r_bstate) == B_ROUND && $past(r_round) == LAST_ROUND))
        else $error("add step entered without completing 64 rounds");

    // a fresh block starts at round zero
    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == B_ROUND && $past(r_bstate) == B_IDLE) |-> (r_round == '0))
        else $error("block started at a nonzero round");

    // chaining value returns to the initial hash after the last digest word
    a_chain_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_idx == LAST_WORD_IDX) |=> (r_chain == H_INIT))
        else $error("chaining value not restored after digest");

endmodule

`default_nettype wire

[bench/sha256md_checker.sv]
`timescale 1ns / 1ps
// digest checker for sha256_message_digest: follows both channels, predicts
// every digest word from the accepted input beats and compares; needs sha256md_pkg

module sha256md_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_in_stall,
    input  sha256md_pkg::t_in_beat  i_in_beat,
    input  wire                     i_out_valid,
    input  wire                     i_out_stall,
    input  sha256md_pkg::t_out_beat i_out_beat,
    output int                      o_fail_count,
    output int                      o_words_due
);
    import sha256md_pkg::*;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // predicted hashing state
    logic [31:0] chain_h [8];
    logic [31:0] blk_w [16];
    logic [5:0]  blk_fill;
    logic [63:0] bit_len;

    // digest words still owed by the block, oldest first
    t_out_beat digest_due [$];
    int fail_total = 0;
    int words_due = 0;

    assign o_fail_count = fail_total;
    assign o_words_due  = words_due;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of blk_w into chain_h
    function automatic void fold_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        int t;
        for (t = 0; t < 16; t++) sched[t] = blk_w[t];
        for (t = 16; t < 64; t++) begin
            s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + RND_K[t] + sched[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // big-endian byte placement; offset 0 of a word overwrites the word
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] val);
        logic [31:0] lane;
        lane = {24'b0, val} << {2'd3 - pos[1:0], 3'b000};
        if (pos[1:0] == 2'd0) begin
            blk_w[pos[5:2]] = lane;
        end else begin
            blk_w[pos[5:2]] |= lane;
        end
    endfunction

    // digest prediction for one accepted input beat
    function automatic void absorb_beat(input t_in_beat beat);
        t_out_beat word;
        int k;
        if (beat.has_byte) begin
            place_byte(blk_fill, beat.data_byte);
            bit_len += 64'd8;
            blk_fill += 6'd1;
            if (blk_fill == 6'd0) begin
                fold_block();
            end
        end
        if (beat.last_of_message) begin
            // padding mark, zeros, then the length in the last two words
            place_byte(blk_fill, PAD_BYTE);
            for (k = int'(blk_fill) + 1; k < 64; k++) place_byte(k[5:0], 8'h00);
            if (blk_fill >= 6'd56) begin
                fold_block();
                for (k = 0; k < 16; k++) blk_w[k] = '0;
            end
            blk_w[14] = bit_len[63:32];
            blk_w[15] = bit_len[31:0];
            fold_block();
            for (k = 0; k < 8; k++) begin
                word.digest_word = chain_h[k];
                word.word_index  = k[2:0];
                word.last_word   = (k == 7);
                digest_due.push_back(word);
            end
            for (k = 0; k < 8; k++) chain_h[k] = HASH_IV[k];
            blk_fill = '0;
            bit_len  = '0;
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: digest mismatch on %s, expected %h got %h",
                 $time, field, want, got);
        fail_total++;
    endtask

    // compare each output beat, then predict from each input beat
    always @(posedge i_clk) begin
        t_out_beat want;
        int k;
        if (!i_rst_n) begin
            for (k = 0; k < 8; k++) chain_h[k] = HASH_IV[k];
            for (k = 0; k < 16; k++) blk_w[k] = '0;
            blk_fill = '0;
            bit_len  = '0;
            digest_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digest_due.size() == 0) begin
                    report_mismatch("unexpected beat", '0, i_out_beat.digest_word);
                end else begin
                    want = digest_due.pop_front();
                    if (i_out_beat.digest_word !== want.digest_word)
                        report_mismatch("digest_word", want.digest_word,
                                        i_out_beat.digest_word);
                    if (i_out_beat.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(want.word_index),
                                        32'(i_out_beat.word_index));
                    if (i_out_beat.last_word !== want.last_word)
                        report_mismatch("last_word", 32'(want.last_word),
                                        32'(i_out_beat.last_word));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_beat(i_in_beat);
            end
        end
        words_due = digest_due.size();
    end

endmodule

[bench/sha256_message_digest_tb.sv]
`timescale 1ns / 1ps
// top of the sha256_message_digest bench: clock, reset, byte stream and
// output back-pressure; depends on sha256md_pkg, the block and sha256md_checker

module sha256_message_digest_tb;
    import sha256md_pkg::*;

    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    // handshake seen at the last rising edge
    logic in_took  = 1'b0;
    logic out_took = 1'b0;

    bit random_phase = 1'b0;
    int burst_left   = 0;
    int msg_items    = 0;
    int fail_count;
    int words_due;

    always #2 clk = ~clk;

    sha256_message_digest u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    sha256md_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    always @(posedge clk) begin
        in_took  <= in_valid && !in_stall;
        out_took <= out_valid && !out_stall;
    end

    function automatic t_in_beat mk_beat(input logic [7:0] data, input logic has,
                                         input logic last);
        t_in_beat beat;
        beat.data_byte       = data;
        beat.has_byte        = has;
        beat.last_of_message = last;
        return beat;
    endfunction

    // offer one beat in bursts with random gaps; returns after its acceptance
    task automatic send_beat(input t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(negedge clk);
        while (!in_took) @(negedge clk);
        burst_left--;
    endtask

    // one message of random bytes, with stray empty beats mixed in
    task automatic send_message(input int len);
        bit join_last;
        int i;
        join_last = (len != 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                msg_items++;
            end
            send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b1,
                              join_last && (i == len - 1)));
            msg_items++;
        end
        if (!join_last) begin
            send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            msg_items++;
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int len;
        int msg_no;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: stray empty beat, empty message, byte extremes
        send_beat(mk_beat(8'hff, 1'b0, 1'b0));
        send_beat(mk_beat(8'h5a, 1'b0, 1'b1));
        send_beat(mk_beat(8'h00, 1'b1, 1'b1));
        send_beat(mk_beat(8'hff, 1'b1, 1'b1));
        send_beat(mk_beat(8'hff, 1'b1, 1'b0));
        send_beat(mk_beat(8'h00, 1'b0, 1'b0));
        send_beat(mk_beat(8'h00, 1'b1, 1'b0));
        send_beat(mk_beat(8'h3c, 1'b0, 1'b1));
        send_beat(mk_beat(8'h80, 1'b1, 1'b0));
        send_beat(mk_beat(8'h7f, 1'b1, 1'b0));
        send_beat(mk_beat(8'h01, 1'b1, 1'b0));
        send_beat(mk_beat(8'hfe, 1'b1, 1'b1));

        // random messages, a few across the padding and full-block boundaries
        random_phase = 1'b1;
        msg_no = 0;
        while (msg_items < RANDOM_ITEMS) begin
            case (msg_no)
                2: begin
                    len = 55 + $urandom_range(0, 1);
                end
                7: begin
                    len = 64;
                end
                12: begin
                    len = ($urandom_range(0, 1) == 1) ? 63 : 120;
                end
                default: begin
                    len = $urandom_range(0, 12);
                end
            endcase
            send_message(len);
            msg_no++;
        end
        in_valid <= 1'b0;

        while (words_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // output back-pressure: one long hold-off, then changing stall patterns
    initial begin : receiver
        t_stall_mode mode;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (random_phase && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = t_stall_mode'($urandom_range(0, 3));
            repeat ($urandom_range(8, 40)) begin
                case (mode)
                    STALL_NONE: begin
                        out_stall <= 1'b0;
                    end
                    STALL_LIGHT: begin
                        out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    STALL_HEAVY: begin
                        out_stall <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        out_stall <= ~out_stall;
                    end
                endcase
                @(negedge clk);
            end
        end
    end

    // stop a hung run: too many cycles with no beat on either channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge clk);
            if (!rst_n || in_took || out_took) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
